// ----- sv/semfw_pkg.sv -----
// Shared widths, opcodes and status codes of the counting semaphore.
package semfw_pkg;

  localparam int COUNT_W         = 16;
  localparam int ID_W            = 8;
  localparam int OP_W            = 3;
  localparam int ST_W            = 3;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_WAIT     = 3'd0,
    OP_TRYWAIT  = 3'd1,
    OP_POST     = 3'd2,
    OP_GETVALUE = 3'd3,
    OP_DESTROY  = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_WOULD_BLOCK = 3'd2,
    ST_BUSY        = 3'd3,
    ST_DESTROYED   = 3'd4,
    ST_QUEUE_FULL  = 3'd5,
    ST_SATURATED   = 3'd6
  } status_e;

endpackage

// ----- sv/semfw_mem.sv -----
// Waiter id memory: one write port, one read port with registered data.
module semfw_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Store a queued id
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the head entry; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/counting_semaphore_fifo_wait.sv -----
// Top level of the counting semaphore with a queue of waiting ids.
//
// Requests (opcode_i, caller_id_i) enter on a valid/ready channel and each
// produces exactly one result (status_o, count_value_o, woken_valid_o,
// woken_id_o) on a valid/ready output channel.
// A request accepted at one edge shows its result right after that edge.
// Throughput is one request per cycle while the receiver takes results;
// the count, pointers and occupancy sit in flops, and the waiter ids sit
// in a memory whose head entry is read at the accept edge of a post, so
// the woken id is available together with the rest of the result.
// A wait stores its id at the tail at its accept edge; a later post reads
// at a later edge, so no forwarding is needed.
// When the receiver stalls, the result is held and in_ready_o drops until
// the result is taken; a new request is taken in the same cycle the old
// result leaves.
// Reset clears count, pointers, occupancy, the destroyed mark and the
// output valid. The id memory is not cleared: only written entries are read.
// A cfg_we_i write loads the count, empties the queue, clears the destroyed
// mark. Users issue it only while no result is pending; nothing enforces it.
module counting_semaphore_fifo_wait
  import semfw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [ID_W-1:0]    caller_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ST_W-1:0]    status_o,
  output logic [COUNT_W-1:0] count_value_o,
  output logic               woken_valid_o,
  output logic [ID_W-1:0]    woken_id_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic               destroyed_q, destroyed_d;

  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [COUNT_W-1:0] count_out_q;
  logic               woken_q, woken_d;

  logic               accept;
  logic               push, pop;
  logic [MEM_W-1:0]   rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decide the outcome of the request against the current state
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    destroyed_d = destroyed_q;
    status_d    = ST_OK;
    woken_d     = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    if (destroyed_q) begin
      status_d = ST_DESTROYED;
    end else begin
      unique case (opcode_i)
        OP_WAIT: begin
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else if (occ_q == OCC_FULL) begin
            status_d = ST_QUEUE_FULL;
          end else begin
            push     = 1'b1;
            status_d = ST_QUEUED;
          end
        end
        OP_TRYWAIT: begin
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else begin
            status_d = ST_WOULD_BLOCK;
          end
        end
        OP_POST: begin
          if (occ_q != '0) begin
            pop     = 1'b1;
            woken_d = 1'b1;
          end else if (count_q == COUNT_MAX) begin
            status_d = ST_SATURATED;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        OP_DESTROY: begin
          if (occ_q != '0) begin
            status_d = ST_BUSY;
          end else begin
            destroyed_d = 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
    // Advance the queue ends, wrapping at the last slot, and track occupancy
    if (push) begin
      tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
    end
    if (pop) begin
      head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   occ_d = occ_q + 1'b1;
      2'b01:   occ_d = occ_q - 1'b1;
      default: occ_d = occ_q;
    endcase
  end

  // Update the semaphore state; a configuration write reloads it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      destroyed_q <= 1'b0;
    end else if (cfg_we_i) begin
      count_q     <= cfg_wdata_i;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      destroyed_q <= 1'b0;
    end else if (accept) begin
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      destroyed_q <= destroyed_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      count_out_q <= count_d;
      woken_q     <= woken_d;
    end
  end

  // Waiter ids: push at the tail, read the head on a releasing post
  semfw_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (accept && push),
    .wr_addr_i (tail_q),
    .wr_data_i (caller_id_i[MEM_W-1:0]),
    .rd_en_i   (accept && pop),
    .rd_addr_i (head_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign count_value_o = count_out_q;
  assign woken_valid_o = woken_q;
  assign woken_id_o    = woken_q ? ID_W'(rd_data) : '0;

endmodule

// ----- sv/semfw_chk.sv -----
// Port-level checker for the counting semaphore, bound to the top level.
module semfw_chk
  import semfw_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ST_W-1:0]    status_o,
  input logic [COUNT_W-1:0] count_value_o,
  input logic               woken_valid_o,
  input logic [ID_W-1:0]    woken_id_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(count_value_o) && $stable(woken_valid_o) && $stable(woken_id_o))
    else $error("stalled result changed");

  // Report a release only with ok status, and a zero id otherwise
  a_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (woken_valid_o ? (status_o == ST_OK) : (woken_id_o == '0)))
    else $error("woken fields inconsistent with status");

  // Queue or refuse a wait only when the count is empty
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_QUEUED || status_o == ST_WOULD_BLOCK
      || status_o == ST_QUEUE_FULL) |-> count_value_o == '0)
    else $error("wait blocked with a positive count");

  // Saturate only at the top of the count
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SATURATED |-> count_value_o == COUNT_MAX)
    else $error("saturation below the maximum count");

endmodule

bind counting_semaphore_fifo_wait semfw_chk u_semfw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .count_value_o (count_value_o),
  .woken_valid_o (woken_valid_o),
  .woken_id_o    (woken_id_o)
);

// ----- tb/sv/counting_semaphore_fifo_wait_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the counting semaphore with a queue of waiting ids.
module counting_semaphore_fifo_wait_tb;
  import semfw_pkg::*;

  localparam int                QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [ID_W-1:0]   ID_MASK     = ID_W'((1 << ID_BITS_DEF) - 1);
  localparam logic [OP_W-1:0]   OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0]   OP_RSVD_HI  = 3'd7;
  localparam int                RAND_ITEMS  = 650;
  localparam int                SEG_LEN     = 40;
  localparam int                STALL_LIMIT = 2000;
  localparam int                DIR_ROWS    = 17;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] count_value;
    logic               woken_valid;
    logic [ID_W-1:0]    woken_id;
  } sem_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_FIXED} row_kind_e;
  typedef enum logic [1:0] {MIX_WAIT_HEAVY, MIX_POST_HEAVY, MIX_BALANCED} traffic_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [COUNT_W-1:0] cfg_val;
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    id;
    int                 reps;
    sem_result_t        res;
  } dir_row_t;

  localparam sem_result_t NO_RES = '{ST_OK, 16'h0000, 1'b0, 8'h00};

  // Directed requests; fixed rows carry the result read straight off the spec
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_FIXED, 16'h0000, OP_GETVALUE, 8'h00, 1, '{ST_OK, 16'h0000, 1'b0, 8'h00}},
    '{ROW_FIXED, 16'h0000, OP_TRYWAIT,  8'h5A, 1, '{ST_WOULD_BLOCK, 16'h0000, 1'b0, 8'h00}},
    '{ROW_FIXED, 16'h0000, OP_POST,     8'h00, 1, '{ST_OK, 16'h0001, 1'b0, 8'h00}},
    '{ROW_PRED,  16'h0000, OP_WAIT,     8'hA5, 1, NO_RES},
    '{ROW_PRED,  16'h0000, OP_WAIT,     8'h00, 1, NO_RES},
    '{ROW_FIXED, 16'h0000, OP_DESTROY,  8'h00, 1, '{ST_BUSY, 16'h0000, 1'b0, 8'h00}},
    '{ROW_PRED,  16'h0000, OP_POST,     8'h00, 1, NO_RES},
    '{ROW_PRED,  16'h0000, OP_RSVD_HI,  8'hC3, 1, NO_RES},
    '{ROW_FIXED, 16'h0000, OP_DESTROY,  8'h00, 1, '{ST_OK, 16'h0000, 1'b0, 8'h00}},
    '{ROW_FIXED, 16'h0000, OP_WAIT,     8'h3C, 1, '{ST_DESTROYED, 16'h0000, 1'b0, 8'h00}},
    '{ROW_CFG,   16'hFFFF, OP_GETVALUE, 8'h00, 0, NO_RES},
    '{ROW_FIXED, 16'h0000, OP_POST,     8'hFF, 1, '{ST_SATURATED, 16'hFFFF, 1'b0, 8'h00}},
    '{ROW_PRED,  16'h0000, OP_TRYWAIT,  8'h00, 1, NO_RES},
    '{ROW_CFG,   16'h0000, OP_GETVALUE, 8'h00, 0, NO_RES},
    '{ROW_PRED,  16'h0000, OP_WAIT,     8'hF0, QUEUE_DEPTH, NO_RES},
    '{ROW_FIXED, 16'h0000, OP_WAIT,     8'h11, 1, '{ST_QUEUE_FULL, 16'h0000, 1'b0, 8'h00}},
    '{ROW_PRED,  16'h0000, OP_POST,     8'h00, 1, NO_RES}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    opcode_i    = '0;
  logic [ID_W-1:0]    caller_id_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ST_W-1:0]    status_o;
  logic [COUNT_W-1:0] count_value_o;
  logic               woken_valid_o;
  logic [ID_W-1:0]    woken_id_o;

  // Predictor state
  logic [COUNT_W-1:0] sem_count     = '0;
  logic [ID_W-1:0]    waiter_ids[$];
  logic               sem_destroyed = 1'b0;

  sem_result_t        expected_q[$];
  int                 fail_count    = 0;
  int unsigned        send_idle_pct = 13;
  int unsigned        recv_idle_pct = 81;

  counting_semaphore_fifo_wait dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .caller_id_i  (caller_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .count_value_o(count_value_o),
    .woken_valid_o(woken_valid_o),
    .woken_id_o   (woken_id_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the semaphore model and return its result
  function automatic sem_result_t predict_sem(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id);
    sem_result_t res;
    res = NO_RES;
    if (sem_destroyed) begin
      res.status = ST_DESTROYED;
    end else begin
      case (op)
        OP_WAIT: begin
          if (sem_count != 0) begin
            sem_count--;
          end else if (waiter_ids.size() >= QUEUE_DEPTH) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            waiter_ids.push_back(id & ID_MASK);
            res.status = ST_QUEUED;
          end
        end
        OP_TRYWAIT: begin
          if (sem_count != 0) sem_count--;
          else res.status = ST_WOULD_BLOCK;
        end
        OP_POST: begin
          if (waiter_ids.size() != 0) begin
            res.woken_valid = 1'b1;
            res.woken_id    = waiter_ids.pop_front();
          end else if (sem_count == COUNT_MAX) begin
            res.status = ST_SATURATED;
          end else begin
            sem_count++;
          end
        end
        OP_DESTROY: begin
          if (waiter_ids.size() != 0) res.status = ST_BUSY;
          else sem_destroyed = 1'b1;
        end
        default: ;
      endcase
    end
    res.count_value = sem_count;
    return res;
  endfunction

  // Draw an opcode from the traffic mix of the current segment
  function automatic logic [OP_W-1:0] pick_op(input traffic_e mix);
    int unsigned roll;
    int unsigned cut[5];
    roll = $urandom_range(99);
    case (mix)
      MIX_WAIT_HEAVY: cut = '{55, 70, 88, 94, 97};
      MIX_POST_HEAVY: cut = '{15, 25, 85, 92, 96};
      default:        cut = '{30, 45, 75, 87, 92};
    endcase
    if (roll < cut[0]) return OP_WAIT;
    if (roll < cut[1]) return OP_TRYWAIT;
    if (roll < cut[2]) return OP_POST;
    if (roll < cut[3]) return OP_GETVALUE;
    if (roll < cut[4]) return OP_RSVD_LO + OP_W'($urandom_range(OP_RSVD_HI - OP_RSVD_LO));
    return OP_DESTROY;
  endfunction

  // Present one request, hold it until accepted, then queue its result
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input bit fixed, input sem_result_t fixed_res);
    sem_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    caller_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_sem(op, id);
    expected_q.push_back(fixed ? fixed_res : res);
  endtask

  // Drain outstanding results, then load the initial count register
  task automatic load_initial_count(input logic [COUNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sem_count      = value;
    sem_destroyed  = 1'b0;
    waiter_ids.delete();
  endtask

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    sem_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d count_value %0d", status_o, count_value_o);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          fail_count++;
        end
        if (count_value_o !== exp_res.count_value) begin
          $error("count_value: expected %0d, got %0d", exp_res.count_value, count_value_o);
          fail_count++;
        end
        if (woken_valid_o !== exp_res.woken_valid) begin
          $error("woken_valid: expected %0d, got %0d", exp_res.woken_valid, woken_valid_o);
          fail_count++;
        end
        if (woken_id_o !== exp_res.woken_id) begin
          $error("woken_id: expected %0d, got %0d", exp_res.woken_id, woken_id_o);
          fail_count++;
        end
      end
    end
  end

  // Abort when no request or result moves for too long
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t           row;
    int                 items_sent;
    int                 dead_items;
    logic [COUNT_W-1:0] init_val;
    logic [OP_W-1:0]    op;
    traffic_e           mix;
    items_sent = 0;

    // Hold reset, then release it on a clock edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      if (row.kind == ROW_CFG) begin
        load_initial_count(row.cfg_val);
      end else begin
        for (int k = 0; k < row.reps; k++)
          send_request(row.op, row.id + ID_W'(k), row.kind == ROW_FIXED, row.res);
      end
    end

    // Random segments, each starting from a fresh initial count
    while (items_sent < RAND_ITEMS) begin
      if (items_sent < RAND_ITEMS / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 81;
      end else if (items_sent < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(5))
        0:       init_val = 16'h0000;
        1:       init_val = 16'hFFFF;
        2:       init_val = 16'hFFFE;
        3:       init_val = 16'h0001;
        4:       init_val = COUNT_W'($urandom_range(20));
        default: init_val = COUNT_W'($urandom);
      endcase
      load_initial_count(init_val);
      if (init_val >= 16'hFFF0) mix = MIX_POST_HEAVY;
      else mix = traffic_e'($urandom_range(2));
      dead_items = 0;
      for (int i = 0; i < SEG_LEN && dead_items < 4; i++) begin
        op = pick_op(mix);
        send_request(op, ID_W'($urandom), 1'b0, NO_RES);
        items_sent++;
        // cut the segment short once the semaphore is gone
        if (sem_destroyed) dead_items++;
      end
    end

    // Drain the last results and let the pipeline settle
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- counting_semaphore_fifo_wait.f -----
sv/semfw_pkg.sv
sv/semfw_mem.sv
sv/counting_semaphore_fifo_wait.sv
sv/semfw_chk.sv
tb/sv/counting_semaphore_fifo_wait_tb.sv
